// File: rtl/core/bbr_pkg.sv
// Shared types, constants and register codes for the 3x3 box blur block.
// No dependencies; imported by every module of the block.
package bbr_pkg;

    localparam int CFG_W          = 11;
    localparam int IDX_W          = 2;
    localparam int PIX_W          = 32;
    localparam int RGB_W          = 24;
    localparam int CH_W           = 8;
    localparam int NUM_CH         = 3;
    localparam int SUM_W          = 12;   // 9 * 255 fits in 12 bits
    localparam int MUL_W          = 2 * SUM_W;
    localparam int DIV9_MUL       = 3641; // floor(x/9) = (x*3641) >> 15 for x < 2296
    localparam int DIV9_SHIFT     = 15;
    localparam int FIFO_DEPTH     = 4;
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int RST_FRAME_WIDTH  = 800;
    localparam int RST_FRAME_HEIGHT = 600;

    localparam logic [CH_W-1:0]  ALPHA_OPAQUE = 8'hFF;

    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    // one window column update, in step with the line store read data
    typedef struct packed {
        logic             valid;
        logic             col0;
        logic             emit;
        logic             last;
        logic [RGB_W-1:0] up;
        logic [RGB_W-1:0] mid;
        logic [RGB_W-1:0] cur;
    } win_item_t;

    typedef struct packed {
        logic             valid;
        logic [PIX_W-1:0] pixel;
        logic             last;
    } res_beat_t;

endpackage

// File: rtl/core/box_blur_3x3_rgb_unit.sv
// Streaming 3x3 box blur over RGBA8888 frames: top level, stream counters,
// line store control. Uses bbr_pkg, bbr_ram, bbr_window and bbr_out_fifo.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-----------------------------
//   item     | item_valid / item_ready    | op, pixel_in
//   result   | result_valid / result_ready| pixel_out, last_of_frame
//   cfg      | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// One item per clock while item_ready is high; a result passes the line
// store read, the window sum and the divide into the result queue.
// item_ready drops only while four results are queued or in flight.
// Reset clears positions, window and queue; line stores are not cleared.
// cfg_ready is always high; a write to the frame width or height restarts the frame.
module box_blur_3x3_rgb_unit
    import bbr_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  logic             op,
    input  logic [PIX_W-1:0] pixel_in,
    output logic             result_valid,
    input  logic             result_ready,
    output logic [PIX_W-1:0] pixel_out,
    output logic             last_of_frame,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT + 2);
    localparam int ORW  = $clog2(MAX_HEIGHT);
    localparam int M1   = (CW > CFG_W) ? CW : CFG_W;
    localparam int XW   = ((RW > M1) ? RW : M1) + 1;
    localparam int QCW  = $clog2(FIFO_DEPTH + 1);

    function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                   input int maxv);
        logic [CFG_W-1:0] x;
        x = v;
        if (x == '0)
        begin
            x = CFG_W'(1);
        end
        else if (int'(x) > maxv)
        begin
            x = CFG_W'(maxv);
        end
        return x;
    endfunction

    logic [CFG_W-1:0] width_reg, height_reg;
    logic [CW-1:0]    in_col_reg, in_col_next;
    logic [RW-1:0]    in_row_reg, in_row_next;
    logic [CW-1:0]    out_col_reg, out_col_next;
    logic [ORW-1:0]   out_row_reg, out_row_next;

    logic             cfg_write, restart;
    logic             accept, real_px, eff;
    logic             col0, ge1, ge2, emit, last;
    logic [XW-1:0]    col_p1, ocol_p1;

    // stage 1: line store data returns
    logic             s1_valid_reg;
    logic [CW-1:0]    s1_col_reg;
    logic [RGB_W-1:0] s1_pix_reg;
    logic             s1_real_reg, s1_ge1_reg, s1_ge2_reg;
    logic             s1_col0_reg, s1_emit_reg, s1_last_reg;
    logic             s1_fwd_reg;
    logic [RGB_W-1:0] fwd_up_reg, fwd_mid_reg;
    logic             fwd_next;

    logic [RGB_W-1:0] rd_up, rd_mid;
    logic [RGB_W-1:0] up_eff, mid_eff, cur_eff;
    logic             ls_we;

    win_item_t        win_item;
    res_beat_t        push;
    logic             s2_busy;
    logic [QCW-1:0]   q_count;
    logic [QCW:0]     load;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign restart   = cfg_write &&
                       ((cfg_index == REG_FRAME_WIDTH) || (cfg_index == REG_FRAME_HEIGHT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= clamp_dim(CFG_W'(RST_FRAME_WIDTH), MAX_WIDTH);
            height_reg <= clamp_dim(CFG_W'(RST_FRAME_HEIGHT), MAX_HEIGHT);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  width_reg  <= clamp_dim(cfg_data, MAX_WIDTH);
                REG_FRAME_HEIGHT: height_reg <= clamp_dim(cfg_data, MAX_HEIGHT);
                default: ;
            endcase
        end
    end

    // credit check: every result in flight has a queue slot waiting
    assign load = (QCW+1)'(q_count) + (QCW+1)'(s1_valid_reg && s1_emit_reg)
                + (QCW+1)'(s2_busy);
    assign item_ready = (load < (QCW+1)'(FIFO_DEPTH));

    assign accept  = item_valid && item_ready;
    assign real_px = XW'(in_row_reg) < XW'(height_reg);
    // a flush beat during the frame is dropped without touching state
    assign eff     = accept && !(op && real_px);

    assign col0 = (in_col_reg == '0);
    assign ge1  = (in_row_reg != '0);
    assign ge2  = (in_row_reg[RW-1:1] != '0);
    assign emit = (!col0 && ge1) || (col0 && ge2);
    assign last = (XW'(out_row_reg) + XW'(1) == XW'(height_reg)) &&
                  (XW'(out_col_reg) + XW'(1) == XW'(width_reg));

    assign col_p1  = XW'(in_col_reg) + XW'(1);
    assign ocol_p1 = XW'(out_col_reg) + XW'(1);

    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (restart)
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else if (eff)
        begin
            if (col_p1 >= XW'(width_reg))
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + 1'b1;
            end
            else
            begin
                in_col_next = col_p1[CW-1:0];
            end
            if (emit)
            begin
                if (ocol_p1 >= XW'(width_reg))
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + 1'b1;
                end
                else
                begin
                    out_col_next = ocol_p1[CW-1:0];
                end
                if (last)
                begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            s1_valid_reg <= eff;
        end
    end

    // write in stage 1 meets a read of the same column when the frame is one
    // pixel wide: pass the write data straight to the next beat
    assign fwd_next = s1_valid_reg && s1_real_reg && (s1_col_reg == in_col_reg);

    always_ff @(posedge clk)
    begin
        if (eff)
        begin
            s1_col_reg  <= in_col_reg;
            s1_pix_reg  <= pixel_in[PIX_W-1 -: RGB_W];
            s1_real_reg <= real_px;
            s1_ge1_reg  <= ge1;
            s1_ge2_reg  <= ge2;
            s1_col0_reg <= col0;
            s1_emit_reg <= emit;
            s1_last_reg <= last;
            s1_fwd_reg  <= fwd_next;
            fwd_up_reg  <= mid_eff;
            fwd_mid_reg <= s1_pix_reg;
        end
    end

    assign up_eff  = !s1_ge2_reg ? '0 : (s1_fwd_reg ? fwd_up_reg : rd_up);
    assign mid_eff = !s1_ge1_reg ? '0 : (s1_fwd_reg ? fwd_mid_reg : rd_mid);
    assign cur_eff = s1_real_reg ? s1_pix_reg : '0;
    assign ls_we   = s1_valid_reg && s1_real_reg;

    bbr_ram #(
        .WIDTH (RGB_W),
        .DEPTH (MAX_WIDTH)
    ) u_ls_upper (
        .clk   (clk),
        .we    (ls_we),
        .waddr (s1_col_reg),
        .wdata (mid_eff),
        .re    (eff),
        .raddr (in_col_reg),
        .rdata (rd_up)
    );

    bbr_ram #(
        .WIDTH (RGB_W),
        .DEPTH (MAX_WIDTH)
    ) u_ls_middle (
        .clk   (clk),
        .we    (ls_we),
        .waddr (s1_col_reg),
        .wdata (s1_pix_reg),
        .re    (eff),
        .raddr (in_col_reg),
        .rdata (rd_mid)
    );

    assign win_item.valid = s1_valid_reg;
    assign win_item.col0  = s1_col0_reg;
    assign win_item.emit  = s1_emit_reg;
    assign win_item.last  = s1_last_reg;
    assign win_item.up    = up_eff;
    assign win_item.mid   = mid_eff;
    assign win_item.cur   = cur_eff;

    bbr_window u_window (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (restart),
        .item  (win_item),
        .push  (push),
        .busy  (s2_busy)
    );

    bbr_out_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_out_fifo (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .pixel_out     (pixel_out),
        .last_of_frame (last_of_frame),
        .count         (q_count)
    );

endmodule

// File: rtl/core/bbr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on bbr_pkg for default sizes.
module bbr_ram
    import bbr_pkg::*;
#(
    parameter int WIDTH = RGB_W,
    parameter int DEPTH = DEF_MAX_WIDTH
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/bbr_window.sv
// 3x3 window registers, per-channel neighbourhood sums and divide by nine.
// Depends on bbr_pkg (win_item_t, res_beat_t, width constants).
module bbr_window
    import bbr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      clear,
    input  win_item_t item,
    output res_beat_t push,
    output logic      busy
);

    // [column][row]: column 0 oldest, row 0 top
    logic [RGB_W-1:0] win_reg [0:2][0:2];
    logic [RGB_W-1:0] new_col [0:2];
    logic [SUM_W-1:0] sum_next [0:NUM_CH-1];
    logic [SUM_W-1:0] s2_sum_reg [0:NUM_CH-1];
    logic             s2_valid_reg;
    logic             s2_last_reg;
    logic [MUL_W-1:0] prod [0:NUM_CH-1];
    logic [CH_W-1:0]  quot [0:NUM_CH-1];

    assign new_col[0] = item.up;
    assign new_col[1] = item.mid;
    assign new_col[2] = item.cur;

    // right-edge output (col0) sums the old two newest columns only
    always_comb
    begin
        for (int k = 0; k < NUM_CH; k++)
        begin
            sum_next[k] = '0;
            for (int r = 0; r < 3; r++)
            begin
                sum_next[k] = sum_next[k]
                    + SUM_W'(win_reg[1][r][RGB_W-1-k*CH_W -: CH_W])
                    + SUM_W'(win_reg[2][r][RGB_W-1-k*CH_W -: CH_W])
                    + (item.col0 ? SUM_W'(0) : SUM_W'(new_col[r][RGB_W-1-k*CH_W -: CH_W]));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < 3; c++)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    win_reg[c][r] <= '0;
                end
            end
        end
        else if (clear || (item.valid && item.emit && item.last))
        begin
            for (int c = 0; c < 3; c++)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    win_reg[c][r] <= '0;
                end
            end
        end
        else if (item.valid)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[0][r] <= item.col0 ? '0 : win_reg[1][r];
                win_reg[1][r] <= item.col0 ? '0 : win_reg[2][r];
                win_reg[2][r] <= new_col[r];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= item.valid && item.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.emit)
        begin
            s2_sum_reg  <= sum_next;
            s2_last_reg <= item.last;
        end
    end

    always_comb
    begin
        for (int k = 0; k < NUM_CH; k++)
        begin
            prod[k] = MUL_W'(s2_sum_reg[k]) * MUL_W'(DIV9_MUL);
            quot[k] = prod[k][DIV9_SHIFT +: CH_W];
        end
    end

    assign push.valid = s2_valid_reg;
    assign push.pixel = {quot[0], quot[1], quot[2], ALPHA_OPAQUE};
    assign push.last  = s2_last_reg;
    assign busy       = s2_valid_reg;

endmodule

// File: rtl/core/bbr_out_fifo.sv
// Result queue between the blur pipeline and the output channel.
// Depends on bbr_pkg (res_beat_t, FIFO_DEPTH, PIX_W).
module bbr_out_fifo
    import bbr_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  res_beat_t                  push,
    output logic                       result_valid,
    input  logic                       result_ready,
    output logic [PIX_W-1:0]           pixel_out,
    output logic                       last_of_frame,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [PIX_W-1:0] pix_mem [0:DEPTH-1];
    logic             last_mem [0:DEPTH-1];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             pop;

    assign pop = result_valid && result_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push.valid)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push.valid && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push.valid)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            pix_mem[wr_ptr_reg]  <= push.pixel;
            last_mem[wr_ptr_reg] <= push.last;
        end
    end

    assign result_valid  = (cnt_reg != '0);
    assign pixel_out     = pix_mem[rd_ptr_reg];
    assign last_of_frame = last_mem[rd_ptr_reg];
    assign count         = cnt_reg;

endmodule

// File: rtl/core/bbr_checker.sv
// Port-level checks for the box blur top level, attached by bind.
// Depends on bbr_pkg and on the ports of box_blur_3x3_rgb_unit.
module bbr_checker
    import bbr_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             item_valid,
    input logic             item_ready,
    input logic             result_valid,
    input logic             result_ready,
    input logic [PIX_W-1:0] pixel_out,
    input logic             last_of_frame
);

    // a stalled result beat stays up
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result beat dropped while stalled");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(pixel_out) && $stable(last_of_frame))
        else $error("result payload changed while stalled");

    a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> pixel_out[CH_W-1:0] == ALPHA_OPAQUE)
        else $error("alpha byte not opaque");

    // input only backs off when results are queued
    a_credit: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> result_valid)
        else $error("input stalled with no queued result");

    // a result in an idle queue must follow an accepted item
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_valid && item_ready, 3))
        else $error("result without matching input beat");

endmodule

bind box_blur_3x3_rgb_unit bbr_checker u_bbr_checker (.*);
